>>> rtl/srdu_pkg.sv
// Shared constants, types and fixed-point helpers for the sparse row dot and update block.
package srdu_pkg;

	localparam int ROWS = 16;
	localparam int COLS = 1024;
	localparam int DEPTH = ROWS * COLS;
	localparam int WADDR_W = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1;
	localparam int BIDX_W = ($clog2(ROWS) > 0) ? $clog2(ROWS) : 1;

	localparam int ROW_W = 4;
	localparam int COL_W = 10;
	localparam int DATA_W = 32;
	localparam int ACC_W = 48;
	localparam int PROD_W = 64;
	localparam int FRAC_W = 16;

	localparam logic signed [DATA_W-1:0] BIAS_TERM_RST = 32'sd65536;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_BMUL,
		ST_BIAS
	} state_t;

	// Multiplier request: operands and a load strobe for the product register.
	typedef struct packed {
		logic en;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} mul_req_t;

	// Saturate a 49-bit sum to the signed 48-bit range.
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[ACC_W] == v[ACC_W-1]) begin
			r = v[ACC_W-1:0];
		end else if (v[ACC_W]) begin
			r = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(ACC_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Saturate a 49-bit value to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [ACC_W:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[ACC_W:DATA_W-1] == {(ACC_W-DATA_W+2){v[ACC_W]}}) begin
			r = v[DATA_W-1:0];
		end else if (v[ACC_W]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> rtl/srdu_wmem.sv
// Weight store: single-port-write, registered-read synchronous memory.
module srdu_wmem (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [srdu_pkg::WADDR_W-1:0]         waddr,
	input  logic signed [srdu_pkg::DATA_W-1:0]   wdata,
	input  logic                                 re,
	input  logic [srdu_pkg::WADDR_W-1:0]         raddr,
	output logic signed [srdu_pkg::DATA_W-1:0]   rdata
);

	logic signed [srdu_pkg::DATA_W-1:0] mem_q [srdu_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/srdu_mul.sv
// Shared signed 32x32 multiplier with registered full-width product.
module srdu_mul (
	input  logic                                 clk,
	input  srdu_pkg::mul_req_t                   req,
	output logic signed [srdu_pkg::PROD_W-1:0]   prod
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod <= srdu_pkg::PROD_W'(req.a) * srdu_pkg::PROD_W'(req.b);
		end
	end

endmodule

>>> rtl/sparse_row_dot_and_update.sv
// Top level: sequencer, accumulator, bias weights and result register.
//
// Sparse row dot product and row update engine. Each beat on start carries one
// nonzero element of a sparse vector; busy stays high while the element is
// worked. A non-last element is worked in order as a weight memory read, a pass
// through the shared multiplier and an accumulate or write-back; a last element
// then also puts the bias product through the same multiplier and applies the
// bias step. The result of a last element appears on done, score_sum and
// was_update for exactly one cycle; the receiver cannot stall, so take it then.
// After reset the weight memory is cleared one entry per cycle, all ROWS*COLS =
// 16384 entries, with busy high; cfg_we writes to bias_term are taken at any time.
module sparse_row_dot_and_update (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration: bias_term
	input  logic                                 cfg_we,
	input  logic signed [srdu_pkg::DATA_W-1:0]   cfg_wdata,
	// element beat
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 mode,
	input  logic [srdu_pkg::ROW_W-1:0]           row,
	input  logic [srdu_pkg::COL_W-1:0]           col,
	input  logic signed [srdu_pkg::DATA_W-1:0]   elem_value,
	input  logic signed [srdu_pkg::DATA_W-1:0]   step_scale,
	input  logic                                 last,
	// result beat
	output logic                                 done,
	output logic signed [srdu_pkg::DATA_W-1:0]   score_sum,
	output logic                                 was_update
);

	srdu_pkg::state_t state_q, state_d;

	// item registers
	logic                                 mode_q;
	logic                                 last_q;
	logic                                 ok_q;
	logic                                 row_ok_q;
	logic [srdu_pkg::BIDX_W-1:0]          bidx_q;
	logic [srdu_pkg::WADDR_W-1:0]         addr_q;
	logic signed [srdu_pkg::DATA_W-1:0]   val_q;
	logic signed [srdu_pkg::DATA_W-1:0]   scl_q;

	logic signed [srdu_pkg::DATA_W-1:0]   bias_term_q;
	logic signed [srdu_pkg::DATA_W-1:0]   bias_q [srdu_pkg::ROWS];
	logic signed [srdu_pkg::ACC_W-1:0]    acc_q;
	logic [srdu_pkg::WADDR_W-1:0]         clr_addr_q;

	logic                                 done_q;
	logic signed [srdu_pkg::DATA_W-1:0]   score_sum_q;
	logic                                 was_update_q;

	// control from the output decoder
	logic accept;
	logic mem_re;
	logic mem_we;
	logic clr_step;
	logic acc_ld;
	logic bias_ld;
	logic res_fire;
	srdu_pkg::mul_req_t mul_req;

	// datapath
	logic                                 in_row_ok;
	logic                                 in_ok;
	logic [srdu_pkg::WADDR_W-1:0]         in_addr;
	logic [srdu_pkg::WADDR_W-1:0]         mem_waddr;
	logic signed [srdu_pkg::DATA_W-1:0]   mem_wdata;
	logic signed [srdu_pkg::DATA_W-1:0]   mem_rdata;
	logic signed [srdu_pkg::PROD_W-1:0]   prod;
	logic signed [srdu_pkg::ACC_W-1:0]    prod_q16;
	logic signed [srdu_pkg::DATA_W-1:0]   w_eff;
	logic signed [srdu_pkg::DATA_W-1:0]   bw_eff;
	logic signed [srdu_pkg::DATA_W-1:0]   w_upd;
	logic signed [srdu_pkg::DATA_W-1:0]   b_upd;
	logic signed [srdu_pkg::ACC_W-1:0]    acc_sum;
	logic signed [srdu_pkg::ACC_W-1:0]    score_full;
	logic signed [srdu_pkg::DATA_W-1:0]   score_sat;

	// Address decode for an incoming element; out-of-range entries read as zero.
	assign in_row_ok = 32'(row) < 32'(srdu_pkg::ROWS);
	assign in_ok     = in_row_ok && (32'(col) < 32'(srdu_pkg::COLS));
	assign in_addr   = in_ok ? srdu_pkg::WADDR_W'(32'(row) * 32'(srdu_pkg::COLS) + 32'(col))
	                         : '0;

	// Arithmetic shift floors the Q32.32 product to Q32.16 (16 fraction bits kept).
	assign prod_q16 = prod[srdu_pkg::PROD_W-1:srdu_pkg::FRAC_W];
	assign w_eff    = ok_q ? mem_rdata : '0;
	assign bw_eff   = row_ok_q ? bias_q[bidx_q] : '0;

	assign w_upd      = srdu_pkg::sat_word((srdu_pkg::ACC_W+1)'(mem_rdata) +
	                                       (srdu_pkg::ACC_W+1)'(prod_q16));
	assign b_upd      = srdu_pkg::sat_word((srdu_pkg::ACC_W+1)'(bw_eff) +
	                                       (srdu_pkg::ACC_W+1)'(prod_q16));
	assign acc_sum    = srdu_pkg::sat_acc((srdu_pkg::ACC_W+1)'(acc_q) +
	                                      (srdu_pkg::ACC_W+1)'(prod_q16));
	assign score_full = acc_sum;
	assign score_sat  = srdu_pkg::sat_word((srdu_pkg::ACC_W+1)'(score_full));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srdu_pkg::ST_CLEAR: begin
				if (clr_addr_q == srdu_pkg::WADDR_W'(srdu_pkg::DEPTH - 1)) begin
					state_d = srdu_pkg::ST_IDLE;
				end
			end
			srdu_pkg::ST_IDLE: begin
				if (start) begin
					state_d = srdu_pkg::ST_MUL;
				end
			end
			srdu_pkg::ST_MUL: begin
				state_d = srdu_pkg::ST_ACC;
			end
			srdu_pkg::ST_ACC: begin
				state_d = last_q ? srdu_pkg::ST_BMUL : srdu_pkg::ST_IDLE;
			end
			srdu_pkg::ST_BMUL: begin
				state_d = srdu_pkg::ST_BIAS;
			end
			srdu_pkg::ST_BIAS: begin
				state_d = srdu_pkg::ST_IDLE;
			end
			default: begin
				state_d = srdu_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs.
	always_comb begin
		busy        = 1'b1;
		accept      = 1'b0;
		mem_re      = 1'b0;
		mem_we      = 1'b0;
		clr_step    = 1'b0;
		acc_ld      = 1'b0;
		bias_ld     = 1'b0;
		res_fire    = 1'b0;
		mul_req.en  = 1'b0;
		mul_req.a   = scl_q;
		mul_req.b   = val_q;
		unique case (state_q)
			srdu_pkg::ST_CLEAR: begin
				mem_we   = 1'b1;
				clr_step = 1'b1;
			end
			srdu_pkg::ST_IDLE: begin
				busy   = 1'b0;
				accept = start;
				mem_re = start;
			end
			srdu_pkg::ST_MUL: begin
				// score: weight * value; update: scale * value
				mul_req.en = 1'b1;
				mul_req.a  = mode_q ? scl_q : w_eff;
				mul_req.b  = val_q;
			end
			srdu_pkg::ST_ACC: begin
				mem_we = mode_q && ok_q;
				acc_ld = !mode_q;
			end
			srdu_pkg::ST_BMUL: begin
				// score: bias_term * bias weight; update: scale * bias_term
				mul_req.en = 1'b1;
				mul_req.a  = mode_q ? scl_q : bias_term_q;
				mul_req.b  = mode_q ? bias_term_q : bw_eff;
			end
			srdu_pkg::ST_BIAS: begin
				bias_ld  = mode_q && row_ok_q;
				res_fire = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Write port: zero fill during the clearing pass, else write back the update.
	assign mem_waddr = clr_step ? clr_addr_q : addr_q;
	assign mem_wdata = clr_step ? '0 : w_upd;

	srdu_wmem u_wmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (in_addr),
		.rdata (mem_rdata)
	);

	srdu_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srdu_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			bias_term_q <= srdu_pkg::BIAS_TERM_RST;
			acc_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_fire;
			if (clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cfg_we) begin
				bias_term_q <= cfg_wdata;
			end
			// hold the running score across update beats; drop it once a score closes
			if (acc_ld) begin
				acc_q <= acc_sum;
			end else if (res_fire && !mode_q) begin
				acc_q <= '0;
			end
		end
	end

	// Bias weights: reset to zero, one row written at the close of an update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srdu_pkg::ROWS; i++) begin
				bias_q[i] <= '0;
			end
		end else if (bias_ld) begin
			bias_q[bidx_q] <= b_upd;
		end
	end

	// Item capture and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			last_q   <= last;
			ok_q     <= in_ok;
			row_ok_q <= in_row_ok;
			bidx_q   <= srdu_pkg::BIDX_W'(row);
			addr_q   <= in_addr;
			val_q    <= elem_value;
			scl_q    <= step_scale;
		end
		if (res_fire) begin
			score_sum_q  <= mode_q ? '0 : score_sat;
			was_update_q <= mode_q;
		end
	end

	assign done       = done_q;
	assign score_sum  = score_sum_q;
	assign was_update = was_update_q;

endmodule

>>> dv/tb_sparse_row_dot_and_update.sv
// Self-checking testbench for the sparse row dot product and row update engine.
module tb_sparse_row_dot_and_update;
	timeunit 1ns;
	timeprecision 1ps;

	// Element modes as carried on the mode port.
	localparam logic MODE_SCORE  = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	// Handy Q16.16 values.
	localparam logic signed [srdu_pkg::DATA_W-1:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [srdu_pkg::DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [srdu_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [srdu_pkg::DATA_W-1:0] Q_LSB = 32'sh0000_0001;
	localparam logic signed [srdu_pkg::DATA_W-1:0] Q_NEG_LSB = 32'shffff_ffff;

	// Saturation bounds of the weight words and of the score accumulator.
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -WORD_MAX - 1;
	localparam longint ACC_MAX = 64'sd140737488355327;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	// Settling margin after the block goes quiet; used before config writes and at the end.
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 200;
	localparam int RANDOM_ITEMS = 1700;

	typedef struct {
		logic                               mode;
		logic [srdu_pkg::ROW_W-1:0]         row;
		logic [srdu_pkg::COL_W-1:0]         col;
		logic signed [srdu_pkg::DATA_W-1:0] value;
		logic signed [srdu_pkg::DATA_W-1:0] scale;
		logic                               last;
	} elem_t;

	typedef struct {
		logic signed [srdu_pkg::DATA_W-1:0] score;
		logic                               upd;
	} row_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_we;
	logic signed [srdu_pkg::DATA_W-1:0] cfg_wdata;
	logic                               start;
	logic                               busy;
	logic                               mode;
	logic [srdu_pkg::ROW_W-1:0]         row;
	logic [srdu_pkg::COL_W-1:0]         col;
	logic signed [srdu_pkg::DATA_W-1:0] elem_value;
	logic signed [srdu_pkg::DATA_W-1:0] step_scale;
	logic                               last;
	logic                               done;
	logic signed [srdu_pkg::DATA_W-1:0] score_sum;
	logic                               was_update;

	sparse_row_dot_and_update DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.row        (row),
		.col        (col),
		.elem_value (elem_value),
		.step_scale (step_scale),
		.last       (last),
		.done       (done),
		.score_sum  (score_sum),
		.was_update (was_update)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block's state, kept in step with accepted beats.
	bit signed [srdu_pkg::DATA_W-1:0] weight_shadow [0:srdu_pkg::DEPTH-1];
	bit signed [srdu_pkg::DATA_W-1:0] bias_shadow [0:srdu_pkg::ROWS-1];
	longint                           acc_shadow;
	logic signed [srdu_pkg::DATA_W-1:0] bias_term_shadow;

	// Results still owed by the block, oldest first.
	row_result_t pending_results[$];
	row_result_t want;

	int err_cnt = 0;
	int n_elems = 0;
	int n_scores = 0;
	int n_updates = 0;
	int n_cfg = 0;

	// Sender burst state: start stays high across a burst, drops for a gap after it.
	int burst_left = 0;
	int gap_len = 1;

	// Columns that most random beats hit, so scores see weights that were updated.
	int hot_cols [8] = '{0, 1, 2, 300, 511, 512, 1022, 1023};

	// Q16.16 product, exact in 64 bits, floored back to Q16.16.
	function automatic longint qmul(input logic signed [srdu_pkg::DATA_W-1:0] a,
		input logic signed [srdu_pkg::DATA_W-1:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> srdu_pkg::FRAC_W;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// Advance the shadow state by one beat; returns 1 when the beat closes a vector.
	function automatic bit apply_element(input elem_t e, output row_result_t r);
		bit     row_ok;
		bit     in_range;
		int     idx;
		longint sum;
		longint bw;
		row_ok = int'(e.row) < srdu_pkg::ROWS;
		in_range = row_ok && (int'(e.col) < srdu_pkg::COLS);
		idx = in_range ? int'(e.row) * srdu_pkg::COLS + int'(e.col) : 0;
		r.score = '0;
		r.upd = 1'b0;
		if (e.mode == MODE_UPDATE) begin
			if (in_range) begin
				sum = longint'(weight_shadow[idx]) + qmul(e.scale, e.value);
				weight_shadow[idx] = srdu_pkg::DATA_W'(clamp(sum, WORD_MIN, WORD_MAX));
			end
			if (!e.last) return 1'b0;
			if (row_ok) begin
				sum = longint'(bias_shadow[e.row]) + qmul(e.scale, bias_term_shadow);
				bias_shadow[e.row] = srdu_pkg::DATA_W'(clamp(sum, WORD_MIN, WORD_MAX));
			end
			r.upd = 1'b1;
			return 1'b1;
		end
		sum = in_range ? qmul(weight_shadow[idx], e.value) : 0;
		acc_shadow = clamp(acc_shadow + sum, ACC_MIN, ACC_MAX);
		if (!e.last) return 1'b0;
		bw = row_ok ? longint'(bias_shadow[e.row]) : 0;
		sum = clamp(acc_shadow + qmul(bias_term_shadow, srdu_pkg::DATA_W'(bw)),
			ACC_MIN, ACC_MAX);
		r.score = srdu_pkg::DATA_W'(clamp(sum, WORD_MIN, WORD_MAX));
		acc_shadow = 0;
		return 1'b1;
	endfunction

	function automatic elem_t mk(input logic m, input int r, input int c,
		input logic signed [srdu_pkg::DATA_W-1:0] v,
		input logic signed [srdu_pkg::DATA_W-1:0] s,
		input logic l);
		elem_t e;
		e.mode = m;
		e.row = srdu_pkg::ROW_W'(r);
		e.col = srdu_pkg::COL_W'(c);
		e.value = v;
		e.scale = s;
		e.last = l;
		return e;
	endfunction

	// Mostly modest magnitudes, with extremes and full-range words mixed in.
	function automatic logic signed [srdu_pkg::DATA_W-1:0] rand_q(input int span_log2);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 6))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return '0;
				3: return Q_LSB;
				4: return Q_NEG_LSB;
				5: return Q_ONE;
				default: return -Q_ONE;
			endcase
		end
		if (pick <= 2) return $urandom;
		return srdu_pkg::DATA_W'($signed($urandom_range(0, (1 << (span_log2 + 1)) - 1))
			- (1 << span_log2));
	endfunction

	function automatic int rand_col();
		if ($urandom_range(0, 3) != 0) return hot_cols[$urandom_range(0, 7)];
		return $urandom_range(0, srdu_pkg::COLS - 1);
	endfunction

	// Send one beat: hold start and the fields until the block takes them.
	task automatic send_elem(input elem_t e);
		row_result_t r;
		if (burst_left == 0) begin
			repeat (gap_len) @(posedge clk);
			// long bursts give stretches with no idling at all
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 8);
		end
		start <= 1'b1;
		mode <= e.mode;
		row <= e.row;
		col <= e.col;
		elem_value <= e.value;
		step_scale <= e.scale;
		last <= e.last;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_elems++;
		if (apply_element(e, r)) pending_results.push_back(r);
		burst_left--;
		if (burst_left == 0) begin
			start <= 1'b0;
			gap_len = $urandom_range(1, 10);
		end
	endtask

	// Drop start, wait for all owed results and for the block to go quiet.
	task automatic drain();
		if (burst_left != 0) begin
			start <= 1'b0;
			burst_left = 0;
			gap_len = 1;
		end
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bias_term(input logic signed [srdu_pkg::DATA_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		bias_term_shadow = v;
		n_cfg++;
	endtask

	// Fresh weights: scores give only the bias product, which is zero here.
	task automatic test_clear_state();
		send_elem(mk(MODE_SCORE, 0, 0, Q_MAX, Q_MAX, 1'b1));
		send_elem(mk(MODE_UPDATE, 1, 1, '0, '0, 1'b1));
	endtask

	// Build a few weights, read them back; includes a floor on a negative product.
	task automatic test_update_then_score();
		send_elem(mk(MODE_UPDATE, 3, 5, 32'sh0002_0000, 32'sh0001_8000, 1'b0));
		send_elem(mk(MODE_UPDATE, 3, 1023, -Q_ONE, 32'sh0000_8000, 1'b1));
		send_elem(mk(MODE_SCORE, 3, 5, Q_ONE, Q_ONE, 1'b0));
		send_elem(mk(MODE_SCORE, 3, 1023, 32'sh0002_0000, '0, 1'b1));
		send_elem(mk(MODE_UPDATE, 15, 0, Q_NEG_LSB, Q_LSB, 1'b0));
		send_elem(mk(MODE_SCORE, 15, 0, Q_ONE, '0, 1'b1));
	endtask

	// An update in the middle of a score vector must leave the running sum alone.
	task automatic test_interleaved_update();
		send_elem(mk(MODE_SCORE, 3, 5, Q_ONE, '0, 1'b0));
		send_elem(mk(MODE_UPDATE, 3, 5, Q_ONE, Q_ONE, 1'b0));
		send_elem(mk(MODE_SCORE, 3, 1023, Q_ONE, '0, 1'b1));
	endtask

	// Drive weights, bias weights, the accumulator and the score into their limits.
	task automatic test_saturation();
		send_elem(mk(MODE_UPDATE, 15, 1023, Q_MAX, Q_MAX, 1'b0));
		send_elem(mk(MODE_UPDATE, 15, 1023, Q_MIN, Q_MIN, 1'b0));
		send_elem(mk(MODE_UPDATE, 14, 1, Q_MAX, Q_MIN, 1'b0));
		repeat (3) send_elem(mk(MODE_SCORE, 15, 1023, Q_MAX, '0, 1'b0));
		send_elem(mk(MODE_SCORE, 15, 1023, Q_MAX, '0, 1'b1));
		send_elem(mk(MODE_SCORE, 14, 1, Q_MAX, '0, 1'b1));
		repeat (2) send_elem(mk(MODE_UPDATE, 2, 2, '0, Q_MAX, 1'b1));
	endtask

	// bias_term at its extremes and at zero, then back to one.
	task automatic test_bias_term_settings();
		write_bias_term(Q_MAX);
		send_elem(mk(MODE_SCORE, 2, 2, '0, '0, 1'b1));
		write_bias_term(Q_MIN);
		send_elem(mk(MODE_SCORE, 2, 2, '0, '0, 1'b1));
		write_bias_term('0);
		send_elem(mk(MODE_UPDATE, 2, 2, '0, Q_MAX, 1'b1));
		send_elem(mk(MODE_SCORE, 2, 2, Q_ONE, '0, 1'b1));
		write_bias_term(Q_ONE);
	endtask

	// Random vectors with random content, some noise beats and some cut-off vectors.
	task automatic test_random_vectors();
		elem_t e;
		int    phase;
		int    sent;
		int    len;
		bit    cut;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_bias_term(Q_ONE);
				1: write_bias_term(rand_q(18));
				2: write_bias_term($urandom);
				default: write_bias_term(-32'sh0003_0000);
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS / 4) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: one beat with everything random
					e.mode = 1'($urandom_range(0, 1));
					e.row = srdu_pkg::ROW_W'($urandom_range(0, srdu_pkg::ROWS - 1));
					e.col = srdu_pkg::COL_W'($urandom_range(0, srdu_pkg::COLS - 1));
					e.value = $urandom;
					e.scale = $urandom;
					e.last = ($urandom_range(0, 2) == 0);
					send_elem(e);
					sent++;
				end else begin
					e.mode = ($urandom_range(0, 4) < 2) ? MODE_UPDATE : MODE_SCORE;
					e.row = srdu_pkg::ROW_W'($urandom_range(0, srdu_pkg::ROWS - 1));
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
						: $urandom_range(1, 6);
					cut = ($urandom_range(0, 11) == 0);
					for (int i = 0; i < len; i++) begin
						e.col = srdu_pkg::COL_W'(rand_col());
						e.value = rand_q(19);
						e.scale = rand_q(16);
						e.last = (i == len - 1) && !cut;
						send_elem(e);
						sent++;
					end
				end
			end
		end
	endtask

	// Compare each result beat with the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (was_update) n_updates++;
			else n_scores++;
			if (pending_results.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: result beat with none owed: score_sum %0d was_update %0b",
						$time, score_sum, was_update);
			end else begin
				want = pending_results.pop_front();
				if (score_sum !== want.score) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: score_sum mismatch: expected %0d, actual %0d",
							$time, want.score, score_sum);
				end
				if (was_update !== want.upd) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: was_update mismatch: expected %0b, actual %0b",
							$time, want.upd, was_update);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		start <= 1'b0;
		mode <= MODE_SCORE;
		row <= '0;
		col <= '0;
		elem_value <= '0;
		step_scale <= '0;
		last <= 1'b0;
		foreach (weight_shadow[i]) weight_shadow[i] = '0;
		foreach (bias_shadow[i]) bias_shadow[i] = '0;
		acc_shadow = 0;
		bias_term_shadow = srdu_pkg::BIAS_TERM_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// the block clears its weight memory first; send_elem waits on busy
		test_clear_state();
		test_update_then_score();
		test_interleaved_update();
		test_saturation();
		test_bias_term_settings();
		test_random_vectors();

		drain();
		$display("Ran %0d element beats: %0d score and %0d update results checked,",
			n_elems, n_scores, n_updates);
		$display("with %0d bias_term writes including both extremes and zero.", n_cfg);
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the memory clear plus every beat at its slowest.
	initial begin
		#2000000;
		$display("Timeout with %0d results still owed", pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
